// ===== rtl/prt_pkg.sv =====
// Shared types and constants for the ping round trip time tracker.
package prt_pkg;

    localparam int unsigned PRT_WINDOW_DEF = 8;
    localparam logic [19:0] PRT_TIMEOUT_RST = 20'd1000;

    typedef enum logic [1:0] {
        MODE_SEND = 2'd0,
        MODE_PONG = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RING,
        S_DIV
    } t_state;

endpackage

// ===== rtl/prt_ring.sv =====
// Sample ring memory with a sequential read sweep that sums the filled entries.
module prt_ring #(
    parameter int unsigned WINDOW = 8,
    parameter int unsigned AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int unsigned CW     = $clog2(WINDOW + 1),
    parameter int unsigned TW     = 32 + CW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic [CW-1:0] i_count,
    output logic          o_done,
    output logic [TW-1:0] o_total
);

    logic [31:0]   r_mem [WINDOW];
    logic [31:0]   r_rd_data;
    logic          r_busy;
    logic          r_rd_pend;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_total;
    logic          w_issue;

    assign w_issue = r_busy && (r_idx < r_count);
    assign o_done  = r_busy && (r_idx == r_count) && !r_rd_pend;
    assign o_total = r_total;

    // write on start, the sweep reads from the next cycle on
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_pend <= 1'b0;
            r_idx     <= '0;
            r_count   <= '0;
            r_total   <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_rd_pend <= 1'b0;
            r_idx     <= '0;
            r_count   <= i_count;
            r_total   <= '0;
        end else begin
            r_rd_pend <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_pend) begin
                r_total <= r_total + TW'(r_rd_data);
            end
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/prt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the window mean.
module prt_div #(
    parameter int unsigned CW = 4,
    parameter int unsigned TW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [31:0]   o_quot
);

    localparam int unsigned NW = $clog2(TW + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [TW-1:0] r_q;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;
    logic [CW:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_q[TW-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign o_done  = r_busy && (r_cnt == NW'(TW));
    assign o_quot  = r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_q    <= '0;
            r_rem  <= '0;
            r_div  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_q   <= {r_q[TW-2:0], w_fit};
            // remainder stays below the divisor, so CW bits hold it
            r_rem <= w_fit ? CW'(w_trial - {1'b0, r_div}) : w_trial[CW-1:0];
        end
    end

endmodule

// ===== rtl/ping_rtt_tracker_unit.sv =====
// Top level of the ping round trip time tracker: control, scalar state and result word.
// Tracks one outstanding ping. Send, tick, unmatched and late-pong words need no sweep
// or division: their result word is registered at acceptance. A pong that yields a sample
// writes the sample ring at acceptance, then sweeps the ring memory one entry per cycle,
// then runs a restoring divider one bit per cycle, and its result word is registered when
// the divider finishes.
// One word is in work at a time; the input is ready when the block is idle and the
// result register is empty or being emptied. The timeout register may be written anytime
// the block is idle.
module ping_rtt_tracker_unit
    import prt_pkg::*;
#(
    parameter int unsigned WINDOW = PRT_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_pong_nonce,
    input  logic        i_link_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ping_issued,
    output logic [31:0] o_issued_nonce,
    output logic        o_sample_taken,
    output logic [31:0] o_latest_rtt,
    output logic [31:0] o_mean_rtt,
    output logic        o_ping_pending,
    output logic [3:0]  o_valid_samples,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_timeout_ms
);

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW = $clog2(WINDOW + 1);
    localparam int unsigned TW = 32 + CW;

    t_state        r_state, n_state;
    logic [19:0]   r_timeout;
    logic          r_pending;
    logic [31:0]   r_sent;
    logic [31:0]   r_nonce;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_fill;
    logic [31:0]   r_last;
    logic [31:0]   r_avg;

    logic          r_out_valid;
    logic          r_o_issued;
    logic [31:0]   r_o_nonce;
    logic          r_o_sample;
    logic [31:0]   r_o_last;
    logic [31:0]   r_o_mean;
    logic          r_o_pending;
    logic [3:0]    r_o_fill;

    logic          w_accept;
    logic [31:0]   w_age;
    logic          w_issue;
    logic          w_match;
    logic          w_sample;
    logic          w_drop;
    logic          n_pending;
    logic [31:0]   n_nonce;
    logic [CW-1:0] n_fill;
    logic [AW-1:0] n_slot;
    logic          w_ring_start;
    logic          w_ring_done;
    logic [TW-1:0] w_total;
    logic          w_div_start;
    logic          w_div_done;
    logic [31:0]   w_quot;

    assign w_accept = i_valid && o_ready;
    assign w_age    = i_now_ms - r_sent;
    assign w_issue  = (t_mode'(i_mode) == MODE_SEND) && i_link_ready && !r_pending;
    assign w_match  = (t_mode'(i_mode) == MODE_PONG) && r_pending
                      && (i_pong_nonce == r_nonce);
    assign w_sample = w_match && (w_age < {12'd0, r_timeout});
    assign w_drop   = (t_mode'(i_mode) == MODE_TICK) && r_pending
                      && (w_age >= {12'd0, r_timeout});

    always_comb begin
        n_pending = r_pending;
        n_nonce   = r_nonce;
        if (w_issue) begin
            n_pending = 1'b1;
            n_nonce   = r_nonce + 32'd1;
        end else if (w_match || w_drop) begin
            n_pending = 1'b0;
        end
        n_fill = (r_fill == CW'(WINDOW)) ? r_fill : r_fill + 1'b1;
        n_slot = (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_sample) begin
                    n_state = S_RING;
                end
            end
            S_RING: begin
                if (w_ring_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready      = 1'b0;
        w_ring_start = 1'b0;
        w_div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready      = !r_out_valid || i_ready;
                w_ring_start = w_accept && w_sample;
            end
            S_RING:  w_div_start = w_ring_done;
            S_DIV:   ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= PRT_TIMEOUT_RST;
            r_pending <= 1'b0;
            r_sent    <= '0;
            r_nonce   <= '0;
            r_slot    <= '0;
            r_fill    <= '0;
            r_last    <= '0;
            r_avg     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_timeout_ms;
            end
            if (w_accept) begin
                r_pending <= n_pending;
                r_nonce   <= n_nonce;
                if (w_issue) begin
                    r_sent <= i_now_ms;
                end
                if (w_sample) begin
                    r_last <= w_age;
                    r_fill <= n_fill;
                    r_slot <= n_slot;
                end
            end
            if (w_div_done) begin
                r_avg <= w_quot;
            end
        end
    end

    // result word: sample words wait for the divider to fill in the mean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= !w_sample;
        end else if (w_div_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o_issued  <= w_issue;
            r_o_nonce   <= w_issue ? n_nonce : 32'd0;
            r_o_sample  <= w_sample;
            r_o_last    <= w_sample ? w_age : r_last;
            r_o_mean    <= r_avg;
            r_o_pending <= n_pending;
            r_o_fill    <= w_sample ? 4'(n_fill) : 4'(r_fill);
        end else if (w_div_done) begin
            r_o_mean <= w_quot;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ping_issued   = r_o_issued;
    assign o_issued_nonce  = r_o_nonce;
    assign o_sample_taken  = r_o_sample;
    assign o_latest_rtt    = r_o_last;
    assign o_mean_rtt      = r_o_mean;
    assign o_ping_pending  = r_o_pending;
    assign o_valid_samples = r_o_fill;
    assign o_cfg_ready     = 1'b1;

    prt_ring #(
        .WINDOW (WINDOW),
        .AW     (AW),
        .CW     (CW),
        .TW     (TW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_ring_start),
        .i_wr_addr (r_slot),
        .i_wr_data (w_age),
        .i_count   (n_fill),
        .o_done    (w_ring_done),
        .o_total   (w_total)
    );

    prt_div #(
        .CW (CW),
        .TW (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_total),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    a_ring_done_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_done |-> r_state == S_RING)
        else $error("ring sweep finished outside its state");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside its state");

    a_out_empty_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RING || r_state == S_DIV) |-> !r_out_valid)
        else $error("result word held while a sample is in work");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW))
        else $error("fill count beyond window");

    a_sample_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> r_fill != '0)
        else $error("mean started with an empty window");

endmodule
